/* hw/rtl/spring_damper_camera_follow_unit_defines.svh */
// ----------------------------------------------------------------------------
// Spring-damper camera follow: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SPRING_DAMPER_CAMERA_FOLLOW_UNIT_DEFINES_SVH
`define SPRING_DAMPER_CAMERA_FOLLOW_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SDCF_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: implication check failed");

// Next-cycle implication.
`define SDCF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

/* hw/rtl/sdcf_pkg.sv */
// ----------------------------------------------------------------------------
// Spring-damper camera follow: shared package
// Payload, configuration and command types, fixed-point helpers and the
// micro-step program that drives the shared multiplier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdcf_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int STEP_W     = 6;
    localparam int MUL_W      = 33;
    localparam int PROD_W     = 66;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_STIFFNESS    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING      = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_MASS = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] CFG_LAG_ENABLE   = CFG_IDX_W'(5);

    // Last micro-step of the geometry part and of the whole spring program
    localparam logic [STEP_W-1:0] LAST_GEOM   = STEP_W'(24);
    localparam logic [STEP_W-1:0] LAST_SPRING = STEP_W'(54);

    localparam logic signed [PROD_W-1:0] S32_MAX = PROD_W'(64'sd2147483647);
    localparam logic signed [PROD_W-1:0] S32_MIN = -PROD_W'(64'sd2147483648);
    localparam logic signed [PROD_W-1:0] MAT_MIN = -PROD_W'(64'sd2147483647);
    localparam logic signed [PROD_W-1:0] RND16   = PROD_W'(64'sd32768);
    localparam logic signed [PROD_W-1:0] RND28   = PROD_W'(64'sd134217728);

    typedef struct packed {
        logic signed [31:0] world_x;
        logic signed [31:0] world_y;
        logic signed [31:0] world_z;
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic [15:0]        time_step;
    } in_t;

    typedef struct packed {
        logic signed [31:0] cam_x;
        logic signed [31:0] cam_y;
        logic signed [31:0] cam_z;
    } out_t;

    typedef struct packed {
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
        logic [31:0]        stiffness;
        logic [31:0]        damping;
        logic [31:0]        inverse_mass;
        logic               lag_enable;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        offset_y:     32'sd0,
        offset_z:     32'sd0,
        stiffness:    32'd655360,
        damping:      32'd131072,
        inverse_mass: 32'd65536,
        lag_enable:   1'b0
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } ctrl_state_t;

    // Multiplier operand A sources
    typedef enum logic [2:0] {
        A_QW,
        A_QX,
        A_QY,
        A_QZ,
        A_MAT,
        A_X,
        A_VEL
    } a_sel_t;

    // Multiplier operand B sources
    typedef enum logic [3:0] {
        B_QW,
        B_QX,
        B_QY,
        B_QZ,
        B_OFFY,
        B_OFFZ,
        B_STIFF,
        B_DAMP,
        B_IMASS,
        B_DT
    } b_sel_t;

    // Write-back operations, applied in the cycle after the product is registered
    typedef enum logic [3:0] {
        WB_NONE,
        WB_LOAD,
        WB_ADD,
        WB_SUB,
        WB_TGT,
        WB_DIFF,
        WB_FS,
        WB_FORCE,
        WB_ACCEL,
        WB_VEL,
        WB_POS
    } wb_op_t;

    typedef struct packed {
        a_sel_t     a_sel;
        b_sel_t     b_sel;
        wb_op_t     wb;
        logic [2:0] idx;
        logic       store;
        logic       dbl;
    } uop_t;

    typedef struct packed {
        uop_t uop;
        logic capture;
        logic out_load;
        logic out_lag;
    } cmd_t;

    localparam uop_t UOP_NOP = '{
        a_sel: A_QW, b_sel: B_QW, wb: WB_NONE, idx: 3'd0, store: 1'b0, dbl: 1'b0
    };

    function automatic logic signed [PROD_W-1:0] sext32(input logic signed [31:0] v);
        return {{(PROD_W-32){v[31]}}, v};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] r;
        if (v > S32_MAX) begin
            r = S32_MAX;
        end
        else if (v < S32_MIN) begin
            r = S32_MIN;
        end
        else begin
            r = v;
        end
        return r[31:0];
    endfunction

    // Matrix entries clamp symmetrically to +-(2^31-1)
    function automatic logic signed [31:0] mat_clamp(input logic signed [PROD_W-1:0] v);
        logic signed [PROD_W-1:0] r;
        if (v > S32_MAX) begin
            r = S32_MAX;
        end
        else if (v < MAT_MIN) begin
            r = MAT_MIN;
        end
        else begin
            r = v;
        end
        return r[31:0];
    endfunction

    // Round half up, then floor
    function automatic logic signed [PROD_W-1:0] rnd_shr16(input logic signed [PROD_W-1:0] v);
        return (v + RND16) >>> 16;
    endfunction

    function automatic logic signed [PROD_W-1:0] rnd_shr28(input logic signed [PROD_W-1:0] v);
        return (v + RND28) >>> 28;
    endfunction

    // Rounded shift of the negated value
    function automatic logic signed [PROD_W-1:0] rnd_neg_shr16(
        input logic signed [PROD_W-1:0] v
    );
        return (RND16 - v) >>> 16;
    endfunction

    function automatic uop_t make_uop(
        input a_sel_t     a,
        input b_sel_t     b,
        input wb_op_t     wb,
        input logic [2:0] idx,
        input logic       store,
        input logic       dbl
    );
        uop_t u;
        u.a_sel = a;
        u.b_sel = b;
        u.wb    = wb;
        u.idx   = idx;
        u.store = store;
        u.dbl   = dbl;
        return u;
    endfunction

    // Micro-step program. Steps 0-15 build the six rotation matrix entries,
    // 16-24 rotate the offset into the three targets, 25-54 run the spring
    // step, ten steps per axis, always on position 0 of the rotating state.
    function automatic uop_t sdcf_program(input logic [STEP_W-1:0] step);
        uop_t u;
        u = UOP_NOP;
        unique case (step)
            6'd0:  u = make_uop(A_QX, B_QY, WB_LOAD, 3'd0, 1'b0, 1'b0);
            6'd1:  u = make_uop(A_QW, B_QZ, WB_SUB,  3'd0, 1'b1, 1'b1);
            6'd2:  u = make_uop(A_QX, B_QZ, WB_LOAD, 3'd0, 1'b0, 1'b0);
            6'd3:  u = make_uop(A_QW, B_QY, WB_ADD,  3'd1, 1'b1, 1'b1);
            6'd4:  u = make_uop(A_QW, B_QW, WB_LOAD, 3'd0, 1'b0, 1'b0);
            6'd5:  u = make_uop(A_QX, B_QX, WB_SUB,  3'd0, 1'b0, 1'b0);
            6'd6:  u = make_uop(A_QY, B_QY, WB_ADD,  3'd0, 1'b0, 1'b0);
            6'd7:  u = make_uop(A_QZ, B_QZ, WB_SUB,  3'd2, 1'b1, 1'b0);
            6'd8:  u = make_uop(A_QY, B_QZ, WB_LOAD, 3'd0, 1'b0, 1'b0);
            6'd9:  u = make_uop(A_QW, B_QX, WB_SUB,  3'd3, 1'b1, 1'b1);
            6'd10: u = make_uop(A_QY, B_QZ, WB_LOAD, 3'd0, 1'b0, 1'b0);
            6'd11: u = make_uop(A_QW, B_QX, WB_ADD,  3'd4, 1'b1, 1'b1);
            6'd12: u = make_uop(A_QW, B_QW, WB_LOAD, 3'd0, 1'b0, 1'b0);
            6'd13: u = make_uop(A_QX, B_QX, WB_SUB,  3'd0, 1'b0, 1'b0);
            6'd14: u = make_uop(A_QY, B_QY, WB_SUB,  3'd0, 1'b0, 1'b0);
            6'd15: u = make_uop(A_QZ, B_QZ, WB_ADD,  3'd5, 1'b1, 1'b0);
            6'd16: u = make_uop(A_MAT, B_OFFY, WB_LOAD, 3'd0, 1'b0, 1'b0);
            6'd17: u = make_uop(A_MAT, B_OFFZ, WB_ADD,  3'd1, 1'b0, 1'b0);
            6'd18: u = make_uop(A_QW,  B_QW,   WB_TGT,  3'd0, 1'b0, 1'b0);
            6'd19: u = make_uop(A_MAT, B_OFFY, WB_LOAD, 3'd2, 1'b0, 1'b0);
            6'd20: u = make_uop(A_MAT, B_OFFZ, WB_ADD,  3'd3, 1'b0, 1'b0);
            6'd21: u = make_uop(A_QW,  B_QW,   WB_TGT,  3'd1, 1'b0, 1'b0);
            6'd22: u = make_uop(A_MAT, B_OFFY, WB_LOAD, 3'd4, 1'b0, 1'b0);
            6'd23: u = make_uop(A_MAT, B_OFFZ, WB_ADD,  3'd5, 1'b0, 1'b0);
            6'd24: u = make_uop(A_QW,  B_QW,   WB_TGT,  3'd2, 1'b0, 1'b0);
            6'd25, 6'd35, 6'd45:
                u = make_uop(A_QW, B_QW, WB_DIFF, 3'd0, 1'b0, 1'b0);
            6'd27, 6'd37, 6'd47:
                u = make_uop(A_X, B_STIFF, WB_FS, 3'd0, 1'b0, 1'b0);
            6'd28, 6'd38, 6'd48:
                u = make_uop(A_VEL, B_DAMP, WB_FORCE, 3'd0, 1'b0, 1'b0);
            6'd30, 6'd40, 6'd50:
                u = make_uop(A_X, B_IMASS, WB_ACCEL, 3'd0, 1'b0, 1'b0);
            6'd32, 6'd42, 6'd52:
                u = make_uop(A_X, B_DT, WB_VEL, 3'd0, 1'b0, 1'b0);
            6'd34, 6'd44, 6'd54:
                u = make_uop(A_VEL, B_DT, WB_POS, 3'd0, 1'b0, 1'b0);
            default: u = UOP_NOP;
        endcase
        return u;
    endfunction

endpackage

/* hw/rtl/spring_damper_camera_follow_unit.sv */
// ----------------------------------------------------------------------------
// Spring-damper camera follow unit
// Rotates a camera offset by a quaternion onto the parent position and, with
// lag on, pulls the camera toward that target through a spring-damper step.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Payload        Moves
//  -------  -------------------  -------------  -----------------------------
//  in       in_valid/in_ready    in_data        one request per tick
//  out      out_valid/out_ready  out_data       one camera position per request
//  cfg      cfg_valid/cfg_ready  cfg_index/data one register write
//
//  A request runs 55 (25 with lag off) micro-steps on one shared 33x33
//  multiplier between its accept, drain and result-load cycles; the next
//  request is accepted only after the result load. Reset restores the
//  register defaults and zeroes camera position and velocity. The output
//  register holds a result while the next request runs; that result waits in
//  its last cycle until out is free. Config writes must come while idle.
//
`timescale 1ns / 1ps

`include "spring_damper_camera_follow_unit_defines.svh"

module spring_damper_camera_follow_unit
    import sdcf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_t                   in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_t                  out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg_reg, cfg_next;
    cmd_t cmd;

    // Configuration registers; writes past the last index drop silently.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_OFFSET_Y:     cfg_next.offset_y     = cfg_data;
                CFG_OFFSET_Z:     cfg_next.offset_z     = cfg_data;
                CFG_STIFFNESS:    cfg_next.stiffness    = cfg_data;
                CFG_DAMPING:      cfg_next.damping      = cfg_data;
                CFG_INVERSE_MASS: cfg_next.inverse_mass = cfg_data;
                CFG_LAG_ENABLE:   cfg_next.lag_enable   = cfg_data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Sequencer: walks the micro-step program and runs both handshakes.
    sdcf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .lag_enable (cfg_reg.lag_enable),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cmd        (cmd)
    );

    // Arithmetic: shared multiplier, accumulator, rotation and spring state.
    sdcf_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .cmd      (cmd),
        .in_data  (in_data),
        .out_data (out_data)
    );

    // Hold off the next request while one is in work.
    `SDCF_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
    // A new result only appears after work on a request, never straight from idle.
    `SDCF_ASSERT_IMPLY(a_result_after_work, $rose(out_valid), $past(!in_ready))

endmodule

/* hw/rtl/sdcf_ctrl.sv */
// ----------------------------------------------------------------------------
// Spring-damper camera follow: controller
// Sequences one request through the micro-step program and owns the
// handshakes of the request and result channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdcf_ctrl
    import sdcf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic lag_enable,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd
);

    ctrl_state_t       state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              out_valid_reg, out_valid_next;
    logic              res_free;
    logic [STEP_W-1:0] last_step;

    assign res_free  = !out_valid_reg || out_ready;
    assign last_step = lag_enable ? LAST_SPRING : LAST_GEOM;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RUN;
                    step_next  = '0;
                end
            end
            ST_RUN:
            begin
                if (step_reg == last_step)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    step_next = step_reg + STEP_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (res_free)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready     = 1'b0;
        cmd.uop      = UOP_NOP;
        cmd.capture  = 1'b0;
        cmd.out_load = 1'b0;
        cmd.out_lag  = lag_enable;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_RUN:
            begin
                cmd.uop = sdcf_program(step_reg);
            end
            ST_DRAIN:
            begin
                cmd.uop = UOP_NOP;
            end
            ST_FINISH:
            begin
                cmd.out_load = res_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

/* hw/rtl/sdcf_datapath.sv */
// ----------------------------------------------------------------------------
// Spring-damper camera follow: datapath
// One shared signed 33x33 multiplier with a registered product, an
// accumulator and the write-back logic for rotation and spring steps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdcf_datapath
    import sdcf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  cmd_t cmd,
    input  in_t  in_data,
    output out_t out_data
);

    // Captured request
    logic signed [31:0] world_reg [3];
    logic signed [15:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic [15:0]        dt_reg;

    // Working registers
    uop_t                     uop_reg;
    logic signed [MUL_W-1:0]  a_op, b_op;
    logic signed [PROD_W-1:0] prod_reg, prod_next;
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic signed [31:0]       mat_reg [6];
    logic signed [31:0]       x_reg, x_next;
    logic signed [31:0]       fs_reg, fs_next;
    logic signed [31:0]       tgt_reg [3];
    logic signed [31:0]       tgt_next [3];

    // Camera state, rotated one place after each axis
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] pos_next [3];
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] vel_next [3];

    out_t out_reg;

    logic signed [PROD_W-1:0] acc_new;
    logic signed [31:0]       mat_val;
    logic signed [31:0]       tgt_val;
    logic signed [31:0]       diff_val;
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [31:0]       prod_sat;
    logic signed [31:0]       force_val;
    logic signed [31:0]       vn_val;
    logic signed [31:0]       pn_val;

    // Operand select
    always_comb
    begin
        unique case (cmd.uop.a_sel)
            A_QW:    a_op = {{(MUL_W-16){qw_reg[15]}}, qw_reg};
            A_QX:    a_op = {{(MUL_W-16){qx_reg[15]}}, qx_reg};
            A_QY:    a_op = {{(MUL_W-16){qy_reg[15]}}, qy_reg};
            A_QZ:    a_op = {{(MUL_W-16){qz_reg[15]}}, qz_reg};
            A_MAT:   a_op = {mat_reg[cmd.uop.idx][31], mat_reg[cmd.uop.idx]};
            A_X:     a_op = {x_reg[31], x_reg};
            A_VEL:   a_op = {vel_reg[0][31], vel_reg[0]};
            default: a_op = '0;
        endcase
        unique case (cmd.uop.b_sel)
            B_QW:    b_op = {{(MUL_W-16){qw_reg[15]}}, qw_reg};
            B_QX:    b_op = {{(MUL_W-16){qx_reg[15]}}, qx_reg};
            B_QY:    b_op = {{(MUL_W-16){qy_reg[15]}}, qy_reg};
            B_QZ:    b_op = {{(MUL_W-16){qz_reg[15]}}, qz_reg};
            B_OFFY:  b_op = {cfg.offset_y[31], cfg.offset_y};
            B_OFFZ:  b_op = {cfg.offset_z[31], cfg.offset_z};
            B_STIFF: b_op = {1'b0, cfg.stiffness};
            B_DAMP:  b_op = {1'b0, cfg.damping};
            B_IMASS: b_op = {1'b0, cfg.inverse_mass};
            B_DT:    b_op = {{(MUL_W-16){1'b0}}, dt_reg};
            default: b_op = '0;
        endcase
    end

    assign prod_next = a_op * b_op;

    // Write-back arithmetic
    always_comb
    begin
        unique case (uop_reg.wb)
            WB_LOAD: acc_new = prod_reg;
            WB_ADD:  acc_new = acc_reg + prod_reg;
            WB_SUB:  acc_new = acc_reg - prod_reg;
            default: acc_new = acc_reg;
        endcase
    end

    assign mat_val   = mat_clamp(uop_reg.dbl ? (acc_new <<< 1) : acc_new);
    assign tgt_val   = sat32(sext32(world_reg[uop_reg.idx[1:0]]) + rnd_shr28(acc_reg));
    assign diff_val  = sat32(sext32(tgt_reg[0]) - sext32(pos_reg[0]));
    assign prod_rnd  = rnd_shr16(prod_reg);
    assign prod_sat  = sat32(prod_rnd);
    assign force_val = sat32(sext32(fs_reg) + sext32(sat32(rnd_neg_shr16(prod_reg))));
    assign vn_val    = sat32(sext32(vel_reg[0]) + prod_rnd);
    assign pn_val    = sat32(sext32(pos_reg[0]) + prod_rnd);

    always_comb
    begin
        acc_next = acc_new;
        x_next   = x_reg;
        fs_next  = fs_reg;
        for (int i = 0; i < 3; i++)
        begin
            tgt_next[i] = tgt_reg[i];
            pos_next[i] = pos_reg[i];
            vel_next[i] = vel_reg[i];
        end
        unique case (uop_reg.wb)
            WB_TGT:   tgt_next[uop_reg.idx[1:0]] = tgt_val;
            WB_DIFF:  x_next  = diff_val;
            WB_FS:    fs_next = prod_sat;
            WB_FORCE: x_next  = force_val;
            WB_ACCEL: x_next  = prod_sat;
            WB_VEL:   vel_next[0] = vn_val;
            WB_POS:
            begin
                // advance to the next axis
                pos_next[0] = pos_reg[1];
                pos_next[1] = pos_reg[2];
                pos_next[2] = pn_val;
                vel_next[0] = vel_reg[1];
                vel_next[1] = vel_reg[2];
                vel_next[2] = vel_reg[0];
                tgt_next[0] = tgt_reg[1];
                tgt_next[1] = tgt_reg[2];
                tgt_next[2] = tgt_reg[0];
            end
            default:  x_next = x_reg;
        endcase
    end

    // Camera state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= '0;
                vel_reg[i] <= '0;
            end
            uop_reg <= UOP_NOP;
        end
        else
        begin
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= pos_next[i];
                vel_reg[i] <= vel_next[i];
            end
            uop_reg <= cmd.uop;
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            world_reg[0] <= in_data.world_x;
            world_reg[1] <= in_data.world_y;
            world_reg[2] <= in_data.world_z;
            qw_reg       <= in_data.quat_w;
            qx_reg       <= in_data.quat_x;
            qy_reg       <= in_data.quat_y;
            qz_reg       <= in_data.quat_z;
            dt_reg       <= in_data.time_step;
        end
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        x_reg    <= x_next;
        fs_reg   <= fs_next;
        for (int i = 0; i < 3; i++)
        begin
            tgt_reg[i] <= tgt_next[i];
        end
        if (uop_reg.store)
        begin
            mat_reg[uop_reg.idx] <= mat_val;
        end
        if (cmd.out_load)
        begin
            if (cmd.out_lag)
            begin
                out_reg.cam_x <= pos_reg[0];
                out_reg.cam_y <= pos_reg[1];
                out_reg.cam_z <= pos_reg[2];
            end
            else
            begin
                out_reg.cam_x <= tgt_reg[0];
                out_reg.cam_y <= tgt_reg[1];
                out_reg.cam_z <= tgt_reg[2];
            end
        end
    end

    assign out_data = out_reg;

endmodule
